// ----- src/pce_pkg.sv -----
// Shared constants, types and bit helpers for the parameterized CRC engine.
`default_nettype none

package pce_pkg;

  localparam int MAX_CRC_BITS = 64;
  localparam int CRC_W        = MAX_CRC_BITS;
  localparam int MAX_BYTES    = MAX_CRC_BITS / 8;
  localparam int SHW          = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CFG_DW       = 64;
  localparam int CFG_IW       = 3;
  localparam int CRC_VALUE_W  = 64;

  typedef enum logic [CFG_IW-1:0] {
    REG_WIDTH_BYTES   = 3'd0,
    REG_POLYNOMIAL    = 3'd1,
    REG_INITIAL_VALUE = 3'd2,
    REG_REFLECT_IN    = 3'd3,
    REG_REFLECT_OUT   = 3'd4,
    REG_FINAL_XOR     = 3'd5
  } cfg_idx_t;

  // Settings in the form the datapath uses them
  typedef struct packed {
    logic [SHW-1:0]   sh;        // bytes between width and MSB of the datapath
    logic [CRC_W-1:0] mask;
    logic [CRC_W-1:0] rpoly;     // reflected polynomial, right aligned
    logic [CRC_W-1:0] poly_la;   // normal polynomial, left aligned
    logic [CRC_W-1:0] init_eff;  // start value, reflected when reflect_in
    logic [CRC_W-1:0] fx;        // final xor masked to the width
    logic             ri;
    logic             swap;      // reflect_in differs from reflect_out
  } cfg_t;

  function automatic logic [CRC_W-1:0] rev_bits(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/pce_ifs.sv -----
// Valid/ready channel interfaces for message bytes and CRC results.
`default_nettype none

interface pce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  logic       last;

  modport source(output valid, output data_byte, output first, output last, input ready);
  modport sink(input valid, input data_byte, input first, input last, output ready);
endinterface

interface pce_out_if;
  logic                            valid;
  logic                            ready;
  logic [pce_pkg::CRC_VALUE_W-1:0] crc_value;

  modport source(output valid, output crc_value, input ready);
  modport sink(input valid, input crc_value, output ready);
endinterface

`default_nettype wire

// ----- src/pce_cfg.sv -----
// Configuration registers and the derived settings used by the fold logic.
`default_nettype none

module pce_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         we,
  input  wire logic [pce_pkg::CFG_IW-1:0]   index,
  input  wire logic [pce_pkg::CFG_DW-1:0]   wdata,
  output pce_pkg::cfg_t                     cfg
);

  logic [3:0]                  width_bytes_r;
  logic [pce_pkg::CRC_W-1:0]   polynomial_r;
  logic [pce_pkg::CRC_W-1:0]   initial_value_r;
  logic                        reflect_in_r;
  logic                        reflect_out_r;
  logic [pce_pkg::CRC_W-1:0]   final_xor_r;

  pce_pkg::cfg_t               cfg_r;
  pce_pkg::cfg_t               cfg_nxt;

  localparam logic [3:0] MAX_B = 4'(pce_pkg::MAX_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_bytes_r   <= 4'd4;
      polynomial_r    <= pce_pkg::CRC_W'(64'h0000_0000_04C1_1DB7);
      initial_value_r <= pce_pkg::CRC_W'(64'h0000_0000_FFFF_FFFF);
      reflect_in_r    <= 1'b1;
      reflect_out_r   <= 1'b1;
      final_xor_r     <= pce_pkg::CRC_W'(64'h0000_0000_FFFF_FFFF);
    end else if (we) begin
      unique case (pce_pkg::cfg_idx_t'(index))
        pce_pkg::REG_WIDTH_BYTES:   width_bytes_r   <= wdata[3:0];
        pce_pkg::REG_POLYNOMIAL:    polynomial_r    <= wdata[pce_pkg::CRC_W-1:0];
        pce_pkg::REG_INITIAL_VALUE: initial_value_r <= wdata[pce_pkg::CRC_W-1:0];
        pce_pkg::REG_REFLECT_IN:    reflect_in_r    <= wdata[0];
        pce_pkg::REG_REFLECT_OUT:   reflect_out_r   <= wdata[0];
        pce_pkg::REG_FINAL_XOR:     final_xor_r     <= wdata[pce_pkg::CRC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [3:0]                  eff;
    logic [pce_pkg::SHW+2:0]     sh8;
    logic [pce_pkg::CRC_W-1:0]   poly_m;
    logic [pce_pkg::CRC_W-1:0]   init_m;
    eff = width_bytes_r;
    if (eff == 4'd0) begin
      eff = 4'd1;
    end
    if (eff > MAX_B) begin
      eff = MAX_B;
    end
    cfg_nxt.sh       = pce_pkg::SHW'(MAX_B - eff);
    sh8              = {cfg_nxt.sh, 3'b000};
    cfg_nxt.mask     = {pce_pkg::CRC_W{1'b1}} >> sh8;
    poly_m           = polynomial_r & cfg_nxt.mask;
    init_m           = initial_value_r & cfg_nxt.mask;
    cfg_nxt.rpoly    = pce_pkg::rev_bits(poly_m) >> sh8;
    cfg_nxt.poly_la  = poly_m << sh8;
    cfg_nxt.init_eff = reflect_in_r ? (pce_pkg::rev_bits(init_m) >> sh8) : init_m;
    cfg_nxt.fx       = final_xor_r & cfg_nxt.mask;
    cfg_nxt.ri       = reflect_in_r;
    cfg_nxt.swap     = reflect_in_r ^ reflect_out_r;
  end

  // Settings change only while idle (user rule, unchecked): lag is unseen
  always_ff @(posedge clk) begin
    cfg_r <= cfg_nxt;
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- src/pce_fold.sv -----
// Folds one byte into the running CRC and forms the finished CRC value.
`default_nettype none

module pce_fold (
  input  pce_pkg::cfg_t                     cfg,
  input  wire logic [pce_pkg::CRC_W-1:0]    running,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         first,
  output logic      [pce_pkg::CRC_W-1:0]    folded,
  output logic      [pce_pkg::CRC_W-1:0]    final_crc
);

  logic [pce_pkg::SHW+2:0] sh8;

  assign sh8 = {cfg.sh, 3'b000};

  always_comb begin
    logic [pce_pkg::CRC_W-1:0] base;
    logic [pce_pkg::CRC_W-1:0] c;
    base = first ? cfg.init_eff : (running & cfg.mask);
    if (cfg.ri) begin
      c = base ^ pce_pkg::CRC_W'(data_byte);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ cfg.rpoly) : (c >> 1);
      end
      folded = c;
    end else begin
      // MSB-first runs left aligned so the top bit is always the datapath MSB
      c = base << sh8;
      c[pce_pkg::CRC_W-1 -: 8] = c[pce_pkg::CRC_W-1 -: 8] ^ data_byte;
      for (int k = 0; k < 8; k++) begin
        c = c[pce_pkg::CRC_W-1] ? ((c << 1) ^ cfg.poly_la) : (c << 1);
      end
      folded = c >> sh8;
    end
  end

  assign final_crc = (cfg.swap ? (pce_pkg::rev_bits(folded) >> sh8) : folded) ^ cfg.fx;

endmodule

`default_nettype wire

// ----- src/parameterized_crc_engine.sv -----
// Top level of the parameterized CRC engine: byte stage, fold and result register.
// Usage:
//   in_ch carries one message byte per word with first/last markers. A word
//   with first restarts the CRC from the configured initial value; a word
//   with last yields one word on out_ch holding the finished CRC, masked to
//   the configured width. Words without last produce no output.
//   cfg_we/cfg_index/cfg_wdata write one register per cycle: 0 width in
//   bytes, 1 polynomial, 2 initial value, 3 reflect in, 4 reflect out,
//   5 final xor. Write only while no message byte is in flight.
// Timing:
//   A word is registered in the byte stage, folded there and, for a last
//   byte, the result is registered in the output register. One byte per
//   cycle sustained while out_ch takes each CRC; the eight-bit fold in
//   pce_fold between the byte stage and the output register sets it.
// Reset (rst_n low, synchronous): both stages empty, running CRC cleared,
//   registers back to CRC-32 settings; in_ch.ready is low during reset.
// Stall: while out_ch holds a CRC that is not taken, a byte with last waits
//   in the byte stage; bytes without last keep flowing.
`default_nettype none

module parameterized_crc_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  pce_in_if.sink                           in_ch,
  pce_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [pce_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [pce_pkg::CFG_DW-1:0]  cfg_wdata
);

  pce_pkg::cfg_t               cfg;

  logic                        s1_vld_r;
  logic [7:0]                  s1_byte_r;
  logic                        s1_first_r;
  logic                        s1_last_r;

  logic                        out_vld_r;
  logic [pce_pkg::CRC_W-1:0]   out_crc_r;
  logic [pce_pkg::CRC_W-1:0]   running_crc_r;

  logic [pce_pkg::CRC_W-1:0]   folded;
  logic [pce_pkg::CRC_W-1:0]   final_crc;
  logic                        adv;
  logic                        take;

  pce_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  pce_fold u_fold (
    .cfg       (cfg),
    .running   (running_crc_r),
    .data_byte (s1_byte_r),
    .first     (s1_first_r),
    .folded    (folded),
    .final_crc (final_crc)
  );

  // Only a last byte needs room in the output register
  assign adv         = s1_vld_r && (!s1_last_r || !out_vld_r || out_ch.ready);
  assign in_ch.ready = rst_n && (!s1_vld_r || adv);
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      running_crc_r <= '0;
    end else begin
      if (take) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        running_crc_r <= folded;
      end
      if (adv && s1_last_r) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_byte_r  <= in_ch.data_byte;
      s1_first_r <= in_ch.first;
      s1_last_r  <= in_ch.last;
    end
    if (adv && s1_last_r) begin
      out_crc_r <= final_crc;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.crc_value = pce_pkg::CRC_VALUE_W'(out_crc_r);

  a_last_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_last_r |=> out_vld_r)
    else $error("last byte left the byte stage without a result");

  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_last_r && out_vld_r && !out_ch.ready |=> s1_vld_r && s1_last_r)
    else $error("last byte dropped while the output was stalled");

  a_plain_flows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_last_r |-> in_ch.ready)
    else $error("byte without last blocked the input");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_vld_r && !out_vld_r)
    else $error("stages not empty after reset");

endmodule

`default_nettype wire
